// ===== design/lph_pkg.sv =====
// Shared types, codes and constants of the linear-probing hash table.
package lph_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int POS_W = 16;
    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] MAX_PROBES_RESET = 11'd50;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } lph_op_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NOT_FOUND   = 3'd1,
        STAT_HALF_FULL   = 3'd2,
        STAT_PROBE_LIMIT = 3'd3,
        STAT_ZERO_KEY    = 3'd4
    } lph_status_t;

    typedef struct packed {
        lph_op_t     opcode;
        logic [63:0] key;
        logic [63:0] value;
    } lph_in_t;

    typedef struct packed {
        lph_status_t status;
        logic [63:0] found_value;
    } lph_out_t;

    typedef struct packed {
        lph_op_t          opcode;
        logic             zero_key;
        logic [63:0]      key;
        logic [63:0]      value;
        logic [POS_W-1:0] home;
    } lph_job_t;

endpackage

// ===== design/linear_probe_hash_table.sv =====
// Each beat passes the front end, the job queue and the probe engine. When CAPACITY is not a
// power of two the front end reduces the key to its home slot one key byte per cycle;
// a zero key skips the reduction and the probe walk. The front end takes no new beat until it
// has pushed its job, and the probe engine takes one job at a time.
// After reset the key store is cleared one slot per cycle, with in_stall held high; max_probes
// resets to 50.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  lph_in_t          in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output lph_out_t         out_data,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data
);

    logic     clearing;
    logic     job_push;
    logic     job_pop;
    logic     job_full;
    logic     job_empty;
    lph_job_t push_data;
    lph_job_t pop_data;

    lph_front #(
        .CAPACITY(CAPACITY)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .clearing (clearing),
        .job_push (job_push),
        .job_data (push_data),
        .job_full (job_full)
    );

    lph_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_data),
        .pop       (job_pop),
        .pop_data  (pop_data),
        .full      (job_full),
        .empty     (job_empty)
    );

    lph_back #(
        .CAPACITY(CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .job_empty (job_empty),
        .job_data  (pop_data),
        .job_pop   (job_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== design/lph_front.sv =====
// Front end: accepts beats, flags zero keys and reduces the key to its home slot.
module lph_front
    import lph_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  lph_in_t  in_data,
    input  logic     clearing,
    output logic     job_push,
    output lph_job_t job_data,
    input  logic     job_full
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam int TW = AW + 9;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MOD  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t   state_reg;
    logic [2:0]     byte_idx_reg;
    lph_job_t       job_reg;
    logic [AW-1:0]  rem_reg;
    logic [AW-1:0]  rem_next;
    logic [7:0]     cur_byte;
    logic [TW-1:0]  t;
    logic           accept;

    assign in_stall = clearing || (state_reg != F_IDLE);
    assign accept   = in_valid && !in_stall;
    assign job_push = (state_reg == F_PUSH) && !job_full;
    assign job_data = job_reg;
    assign cur_byte = job_reg.key[{byte_idx_reg, 3'b000} +: 8];

    // One byte of the key is folded into the remainder per cycle by restoring subtraction.
    always_comb
    begin
        t = {1'b0, rem_reg, cur_byte};
        for (int j = 7; j >= 0; j--)
        begin
            if (t >= (TW'(CAPACITY) << j))
            begin
                t = t - (TW'(CAPACITY) << j);
            end
        end
        rem_next = t[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            byte_idx_reg <= 3'd7;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        byte_idx_reg <= 3'd7;
                        if (IS_POW2 || (in_data.key == '0))
                        begin
                            state_reg <= F_PUSH;
                        end
                        else
                        begin
                            state_reg <= F_MOD;
                        end
                    end
                end
                F_MOD:
                begin
                    byte_idx_reg <= byte_idx_reg - 3'd1;
                    if (byte_idx_reg == 3'd0)
                    begin
                        state_reg <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!job_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg.opcode   <= in_data.opcode;
            job_reg.key      <= in_data.key;
            job_reg.value    <= in_data.value;
            job_reg.zero_key <= (in_data.key == '0);
            job_reg.home     <= POS_W'(in_data.key[AW-1:0]);
            rem_reg          <= '0;
        end
        else if (state_reg == F_MOD)
        begin
            rem_reg <= rem_next;
            if (byte_idx_reg == 3'd0)
            begin
                job_reg.home <= POS_W'(rem_next);
            end
        end
    end

endmodule

// ===== design/lph_fifo.sv =====
// Short job queue between the front end and the probe engine.
module lph_fifo
    import lph_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lph_job_t push_data,
    input  logic     pop,
    output lph_job_t pop_data,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    lph_job_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full     = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("Job pushed into a full queue.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("Job popped from an empty queue.");

endmodule

// ===== design/lph_back.sv =====
// Probe engine: holds the slot stores and walks them one slot per cycle.
module lph_back
    import lph_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             job_empty,
    input  lph_job_t         job_data,
    output logic             job_pop,
    output logic             clearing,
    output logic             out_valid,
    input  logic             out_stall,
    output lph_out_t         out_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = AW + 1;
    localparam int HALF_CAP = (CAPACITY + 1) / 2;

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_CHECK = 3'b100
    } back_state_t;

    back_state_t      state_reg;
    logic [CFG_W-1:0] max_probes_reg;
    logic [AW-1:0]    clr_idx_reg;
    logic [AW-1:0]    step_reg;
    logic [CW-1:0]    count_reg;
    logic             out_valid_reg;
    lph_out_t         out_data_reg;
    logic [AW-1:0]    pos_reg;
    lph_op_t          cur_op_reg;
    logic [63:0]      cur_key_reg;
    logic [63:0]      cur_value_reg;

    logic [63:0]      key_mem [CAPACITY];
    logic [63:0]      val_mem [CAPACITY];
    logic [63:0]      key_rd_reg;
    logic [63:0]      val_rd_reg;

    logic [AW-1:0]    limit;
    logic [AW-1:0]    pos_inc;
    logic [AW-1:0]    head_home;
    logic             out_free;
    logic             hit;
    logic             empty_slot;
    logic             half_full;
    logic             done;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             key_we;
    logic             val_we;
    logic [AW-1:0]    wr_addr;
    logic [63:0]      key_wdata;
    logic             finish;
    lph_status_t      fin_status;
    logic [63:0]      fin_value;
    logic             count_inc;

    assign clearing   = state_reg == B_CLEAR;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign head_home  = job_data.home[AW-1:0];
    assign hit        = key_rd_reg == cur_key_reg;
    assign empty_slot = key_rd_reg == '0;
    assign half_full  = (32'(count_reg) << 1) >= 32'(CAPACITY);
    assign done       = hit || empty_slot || (step_reg == limit);
    assign pos_inc    = ({1'b0, pos_reg} == CW'(CAPACITY - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        if (32'(max_probes_reg) > 32'(CAPACITY - 1))
        begin
            limit = AW'(CAPACITY - 1);
        end
        else
        begin
            limit = AW'(max_probes_reg);
        end
    end

    always_comb
    begin
        job_pop    = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = pos_reg;
        key_we     = 1'b0;
        val_we     = 1'b0;
        wr_addr    = pos_reg;
        key_wdata  = cur_key_reg;
        finish     = 1'b0;
        fin_status = STAT_OK;
        fin_value  = '0;
        count_inc  = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                key_we    = 1'b1;
                wr_addr   = clr_idx_reg;
                key_wdata = '0;
            end
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    if (job_data.zero_key)
                    begin
                        if (out_free)
                        begin
                            job_pop    = 1'b1;
                            finish     = 1'b1;
                            fin_status = STAT_ZERO_KEY;
                        end
                    end
                    else
                    begin
                        job_pop = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = head_home;
                    end
                end
            end
            B_CHECK:
            begin
                if (!done)
                begin
                    rd_en   = 1'b1;
                    rd_addr = pos_inc;
                end
                else if (out_free)
                begin
                    finish = 1'b1;
                    if (hit)
                    begin
                        if (cur_op_reg == OP_PUT)
                        begin
                            val_we = 1'b1;
                        end
                        else
                        begin
                            fin_value = val_rd_reg;
                        end
                    end
                    else if (empty_slot)
                    begin
                        if (cur_op_reg == OP_PUT)
                        begin
                            if (half_full)
                            begin
                                fin_status = STAT_HALF_FULL;
                            end
                            else
                            begin
                                key_we    = 1'b1;
                                val_we    = 1'b1;
                                count_inc = 1'b1;
                            end
                        end
                        else
                        begin
                            fin_status = STAT_NOT_FOUND;
                        end
                    end
                    else
                    begin
                        fin_status = STAT_PROBE_LIMIT;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            max_probes_reg <= MAX_PROBES_RESET;
            clr_idx_reg    <= '0;
            step_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_probes_reg <= cfg_data;
            end
            if (count_inc)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if ({1'b0, clr_idx_reg} == CW'(CAPACITY - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (job_pop && !job_data.zero_key)
                    begin
                        step_reg  <= '0;
                        state_reg <= B_CHECK;
                    end
                end
                B_CHECK:
                begin
                    if (!done)
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                    else if (out_free)
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_op_reg    <= job_data.opcode;
            cur_key_reg   <= job_data.key;
            cur_value_reg <= job_data.value;
            pos_reg       <= head_home;
        end
        else if ((state_reg == B_CHECK) && !done)
        begin
            pos_reg <= pos_inc;
        end
        if (finish)
        begin
            out_data_reg.status      <= fin_status;
            out_data_reg.found_value <= fin_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_wdata;
        end
        if (val_we)
        begin
            val_mem[wr_addr] <= cur_value_reg;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(HALF_CAP))
        else $error("Occupied count exceeds half the capacity.");
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !job_pop)
        else $error("Job taken during the clearing pass.");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHECK) |-> (step_reg <= limit))
        else $error("Probe walk ran past the probe limit.");
    a_count_on_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> $past(count_inc && key_we))
        else $error("Occupied count changed without a key insert.");

endmodule

// ===== tb/tb_linear_probe_hash_table.sv =====
// Self-checking testbench for the linear-probing hash table, with its own table predictor.
module tb_linear_probe_hash_table;
    timeunit 1ns;
    timeprecision 1ps;

    import lph_pkg::*;

    localparam int SLOTS = CAPACITY_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 4000000;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] limit;
        lph_op_t          op;
        logic [63:0]      key;
        logic [63:0]      val;
        bit               typed;
        lph_status_t      st;
        logic [63:0]      fv;
    } stim_row_t;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    lph_in_t          in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    lph_out_t         out_data;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    logic [63:0]      tbl_keys [SLOTS];
    logic [63:0]      tbl_vals [SLOTS];
    int               tbl_used;
    logic [CFG_W-1:0] cur_limit;
    logic [63:0]      key_pool [$];
    lph_out_t         result_q [$];
    lph_out_t         want_res;
    int               errors = 0;
    int               cycles = 0;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    bit               hold_start = 1'b0;
    int               hold_left = 0;
    int               hot_homes [6] = '{0, 1, 2, SLOTS / 2 - 2, SLOTS - 2, SLOTS - 1};

    // Keys whose home slot is the last one wrap round to the first slots.
    stim_row_t dir_rows [0:24] = '{
        '{1'b0, 11'd0, OP_GET, 64'd5, 64'd0, 1'b1, STAT_NOT_FOUND, 64'd0},
        '{1'b0, 11'd0, OP_PUT, 64'd0, '1, 1'b1, STAT_ZERO_KEY, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'd0, 64'd0, 1'b1, STAT_ZERO_KEY, 64'd0},
        '{1'b0, 11'd0, OP_PUT, '1, '1, 1'b1, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_GET, '1, 64'd0, 1'b1, STAT_OK, '1},
        '{1'b0, 11'd0, OP_PUT, 64'h7FF, 64'd0, 1'b1, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'h7FF, 64'd0, 1'b1, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_PUT, 64'h7FF, 64'h8000_0000_0000_0001, 1'b1, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'h7FF, 64'd0, 1'b1, STAT_OK, 64'h8000_0000_0000_0001},
        '{1'b0, 11'd0, OP_PUT, 64'h400, 64'h1234_5678_9ABC_DEF0, 1'b1, STAT_OK, 64'd0},
        '{1'b1, 11'd0, OP_GET, 64'd0, 64'd0, 1'b0, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'h400, 64'd0, 1'b1, STAT_PROBE_LIMIT, 64'd0},
        '{1'b0, 11'd0, OP_PUT, 64'h800, 64'd1, 1'b1, STAT_PROBE_LIMIT, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'h7FF, 64'd0, 1'b1, STAT_PROBE_LIMIT, 64'd0},
        '{1'b0, 11'd0, OP_GET, '1, 64'd0, 1'b1, STAT_OK, '1},
        '{1'b1, 11'd1, OP_GET, 64'd0, 64'd0, 1'b0, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'h400, 64'd0, 1'b1, STAT_OK, 64'h1234_5678_9ABC_DEF0},
        '{1'b0, 11'd0, OP_GET, 64'h800, 64'd0, 1'b1, STAT_PROBE_LIMIT, 64'd0},
        '{1'b1, 11'd2047, OP_GET, 64'd0, 64'd0, 1'b0, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_PUT, 64'h800, 64'h5555_5555_5555_5555, 1'b1, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'hC00, 64'd0, 1'b1, STAT_NOT_FOUND, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'h800, 64'd0, 1'b1, STAT_OK, 64'h5555_5555_5555_5555},
        '{1'b1, 11'd50, OP_GET, 64'd0, 64'd0, 1'b0, STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_PUT, 64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0,
          STAT_OK, 64'd0},
        '{1'b0, 11'd0, OP_GET, 64'h8000_0000_0000_0000, 64'd0, 1'b0, STAT_OK, 64'd0}
    };

    linear_probe_hash_table #(
        .CAPACITY(SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic lph_out_t predict_hash_op(input lph_in_t item);
        lph_out_t res;
        int       span;
        int       pos;
        int       step;
        res.status = STAT_PROBE_LIMIT;
        res.found_value = '0;
        span = (int'(cur_limit) > SLOTS - 1) ? SLOTS - 1 : int'(cur_limit);
        if (item.key == '0)
        begin
            res.status = STAT_ZERO_KEY;
            return res;
        end
        pos = int'(item.key % 64'(SLOTS));
        for (step = 0; step <= span; step++)
        begin
            if (tbl_keys[pos] == item.key)
            begin
                if (item.opcode == OP_PUT)
                    tbl_vals[pos] = item.value;
                else
                    res.found_value = tbl_vals[pos];
                res.status = STAT_OK;
                return res;
            end
            if (tbl_keys[pos] == '0)
            begin
                if (item.opcode == OP_GET)
                    res.status = STAT_NOT_FOUND;
                else if (tbl_used * 2 >= SLOTS)
                    res.status = STAT_HALF_FULL;
                else
                begin
                    tbl_keys[pos] = item.key;
                    tbl_vals[pos] = item.value;
                    tbl_used++;
                    key_pool.push_back(item.key);
                    res.status = STAT_OK;
                end
                return res;
            end
            pos = (pos + 1) % SLOTS;
        end
        return res;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] clustered_key();
        logic [63:0] k;
        k = rand_word();
        return k - (k % 64'(SLOTS)) + 64'(hot_homes[$urandom_range(0, 5)]);
    endfunction

    function automatic logic [63:0] stored_key();
        if (key_pool.size() == 0)
            return rand_word();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    function automatic lph_in_t make_item(input bit fill);
        lph_in_t item;
        int      r;
        r = $urandom_range(0, 99);
        item.value = rand_word();
        item.opcode = OP_PUT;
        if (fill)
        begin
            if (r < 85)
                item.key = rand_word();
            else if (r < 92)
                item.key = stored_key();
            else
            begin
                item.opcode = OP_GET;
                item.key = stored_key();
            end
        end
        else if (r < 3)
        begin
            item.opcode = lph_op_t'($urandom_range(0, 1));
            item.key = '0;
        end
        else if (r < 18)
            item.key = clustered_key();
        else if (r < 33)
            item.key = rand_word();
        else if (r < 50)
            item.key = stored_key();
        else
        begin
            item.opcode = OP_GET;
            if (r < 75)
                item.key = stored_key();
            else if (r < 88)
                item.key = clustered_key();
            else
                item.key = rand_word();
        end
        return item;
    endfunction

    task automatic push_item(input lph_in_t item, input bit typed, input lph_out_t typed_res);
        lph_out_t predicted;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = predict_hash_op(item);
        result_q.push_back(typed ? typed_res : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] limit);
        drain_results();
        cfg_we <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_limit = limit;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] limit, input int idle_pct,
                             input int stall_v, input int n, input bit fill,
                             input bit pressure);
        int i;
        set_limit(limit);
        send_idle_pct = idle_pct;
        stall_pct <= stall_v;
        if (pressure)
        begin
            hold_start <= 1'b1;
            @(posedge clk);
            hold_start <= 1'b0;
        end
        i = 0;
        while (i < n || (fill && tbl_used * 2 < SLOTS))
        begin
            // Halfway through, the sender waits for every outstanding beat to come back.
            if (pressure && i == n / 2)
                drain_results();
            push_item(make_item(fill), 1'b0, '0);
            i++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_start)
        begin
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d value %h", $time,
                         out_data.status, out_data.found_value);
                errors++;
            end
            else
            begin
                want_res = result_q.pop_front();
                if (out_data.status !== want_res.status)
                begin
                    $display("%0t: status mismatch, expected %0d, got %0d", $time,
                             want_res.status, out_data.status);
                    errors++;
                end
                if (out_data.found_value !== want_res.found_value)
                begin
                    $display("%0t: found_value mismatch, expected %h, got %h", $time,
                             want_res.found_value, out_data.found_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
                     cycles, result_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        lph_in_t  item;
        lph_out_t typed_res;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_keys[i] = '0;
            tbl_vals[i] = '0;
        end
        tbl_used = 0;
        cur_limit = MAX_PROBES_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                set_limit(dir_rows[i].limit);
            else
            begin
                item.opcode = dir_rows[i].op;
                item.key = dir_rows[i].key;
                item.value = dir_rows[i].val;
                typed_res.status = dir_rows[i].st;
                typed_res.found_value = dir_rows[i].fv;
                push_item(item, dir_rows[i].typed, typed_res);
            end
        end

        run_phase(11'd50, 0, 0, 100, 1'b0, 1'b0);
        run_phase(11'd0, 60, 0, 80, 1'b0, 1'b0);
        run_phase(11'd1, 0, 60, 80, 1'b0, 1'b0);
        run_phase(11'd3, 13, 13, 80, 1'b0, 1'b1);
        run_phase(11'd2047, 0, 0, 100, 1'b1, 1'b0);
        run_phase(11'd1024, 13, 13, 80, 1'b0, 1'b0);

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== files.f =====
design/lph_pkg.sv
design/lph_front.sv
design/lph_fifo.sv
design/lph_back.sv
design/linear_probe_hash_table.sv
tb/tb_linear_probe_hash_table.sv
